>>> hdl/icdf_pkg.sv
// Shared types and constants for the inverse-CDF table sampler.
// No dependencies; used by icdf_div and inverse_cdf_table_sampler.
package icdf_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = 11;

    // Field widths.
    localparam int ENERGY_W = 32;
    localparam int CDF_W    = 25;
    localparam int FRAC_W   = 24;
    localparam int PROD_W   = FRAC_W + ENERGY_W;

    // Stream widths.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;

    // Request kinds.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Result outcome codes.
    localparam logic [1:0] OUT_INTERP = 2'd0;
    localparam logic [1:0] OUT_FIRST  = 2'd1;
    localparam logic [1:0] OUT_CLAMP  = 2'd2;
    localparam logic [1:0] OUT_FLAT   = 2'd3;

    // One table entry as held in the table memory.
    typedef struct packed {
        logic [CDF_W-1:0]    cdf;
        logic [ENERGY_W-1:0] energy;
    } entry_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

>>> hdl/icdf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on icdf_pkg for widths. The quotient must fit in ENERGY_W bits.
module icdf_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [icdf_pkg::PROD_W-1:0]         dividend,
    input  logic [icdf_pkg::CDF_W-1:0]          divisor,
    output logic                                done,
    output logic [icdf_pkg::ENERGY_W-1:0]       quotient
);

    localparam int QW  = icdf_pkg::ENERGY_W;
    localparam int DW  = icdf_pkg::CDF_W;
    localparam int CW  = $clog2(QW);

    logic [DW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          qbit;

    // Trial subtract of the divisor from the shifted partial remainder.
    always_comb begin
        shifted = {rem_reg, low_reg[QW-1]};
        diff    = {1'b0, shifted} - {2'b00, divisor};
        qbit    = ~diff[DW+1];
    end

    // Control: run for one step per quotient bit, then pulse done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the upper dividend bits seed the remainder, quotient bits
    // shift in where dividend bits shift out.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend[icdf_pkg::PROD_W-1:QW]};
            low_reg <= dividend[QW-1:0];
        end else if (run_reg) begin
            rem_reg <= qbit ? diff[DW-1:0] : shifted[DW-1:0];
            low_reg <= {low_reg[QW-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

>>> hdl/inverse_cdf_table_sampler.sv
// A load writes its entry into the table memory when it is accepted. A sample
// scans the table one entry per cycle from entry 0 until an entry resolves it,
// then goes through the multiply and the 32-step divider when it interpolates.
// Throughput is one request at a time; the table memory read port sets the scan.
// Reset (aresetn low, synchronous) clears control and sets table_length to 1024;
// table contents are kept and are undefined until loaded.
module inverse_cdf_table_sampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration: table_length.
    input  logic                                 cfg_we,
    input  logic [icdf_pkg::LEN_W-1:0]           cfg_wdata,
    // Request stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: entry_index[9:0], entry_energy[41:10], entry_cdf[66:42],
    //        random_fraction[90:67], zero fill[95:91]
    input  logic [icdf_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: action[0]
    input  logic                                 s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: energy[31:0], segment[41:32], zero fill[47:42]
    output logic [icdf_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: outcome[1:0]
    output logic [1:0]                           m_tuser
);

    localparam int IW = icdf_pkg::IDX_W;
    localparam int LW = icdf_pkg::LEN_W;
    localparam int EW = icdf_pkg::ENERGY_W;
    localparam int CW = icdf_pkg::CDF_W;
    localparam int FW = icdf_pkg::FRAC_W;
    localparam int PW = icdf_pkg::PROD_W;

    // Request fields.
    logic [IW-1:0] in_index;
    logic [EW-1:0] in_energy;
    logic [CW-1:0] in_cdf;
    logic [FW-1:0] in_frac;
    logic          in_accept;

    assign in_index  = s_tdata[IW-1:0];
    assign in_energy = s_tdata[IW+EW-1:IW];
    assign in_cdf    = s_tdata[IW+EW+CW-1:IW+EW];
    assign in_frac   = s_tdata[IW+EW+CW+FW-1:IW+EW+CW];
    assign in_accept = s_tvalid && s_tready;

    // Configuration register and its saturated form.
    logic [LW-1:0] table_length_reg;
    logic [LW-1:0] n_used;
    logic [IW-1:0] last_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= LW'(icdf_pkg::TABLE_DEPTH);
        end else if (cfg_we) begin
            table_length_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (table_length_reg < LW'(2)) begin
            n_used = LW'(2);
        end else if (table_length_reg > LW'(icdf_pkg::TABLE_DEPTH)) begin
            n_used = LW'(icdf_pkg::TABLE_DEPTH);
        end else begin
            n_used = table_length_reg;
        end
        last_idx = IW'(n_used - 1'b1);
    end

    // State registers.
    icdf_pkg::state_t state_reg, state_next;

    logic [FW-1:0]        frac_reg;
    logic [IW-1:0]        issue_reg;
    logic                 chk_valid_reg;
    logic [IW-1:0]        chk_idx_reg;
    icdf_pkg::entry_t     rd_data_reg;
    icdf_pkg::entry_t     prev_reg;

    logic [FW-1:0]        dr_reg;
    logic [CW-1:0]        dc_reg;
    logic [EW-1:0]        de_reg;
    logic                 neg_reg;
    logic [EW-1:0]        base_reg;
    logic [PW-1:0]        prod_reg;

    logic [EW-1:0]        res_energy_reg;
    logic [IW-1:0]        res_seg_reg;
    logic [1:0]           res_outcome_reg;

    logic                 m_tvalid_reg;
    logic [EW-1:0]        m_energy_reg;
    logic [IW-1:0]        m_seg_reg;
    logic [1:0]           m_outcome_reg;

    // Table memory: written by loads, read one entry a cycle during a scan.
    icdf_pkg::entry_t tbl_mem [icdf_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == icdf_pkg::ACT_LOAD) begin
            tbl_mem[in_index] <= '{cdf: in_cdf, energy: in_energy};
        end
        rd_data_reg <= tbl_mem[issue_reg];
    end

    // Scan decisions on the entry that just came out of the memory.
    logic          hit;
    logic          at_last;
    logic          flat;
    logic          out_free;
    logic          div_done;
    logic [EW-1:0] div_q;

    always_comb begin
        hit     = rd_data_reg.cdf >= {1'b0, frac_reg};
        at_last = chk_idx_reg == last_idx;
        flat    = (rd_data_reg.cdf <= prev_reg.cdf) || ({1'b0, frac_reg} < prev_reg.cdf);
        out_free = !m_tvalid_reg || m_tready;
    end

    // Next-state logic for the sequencer.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            icdf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == icdf_pkg::ACT_SAMPLE) begin
                    state_next = icdf_pkg::ST_SCAN;
                end
            end
            icdf_pkg::ST_SCAN: begin
                if (chk_valid_reg) begin
                    if (hit) begin
                        if (chk_idx_reg == '0 || flat) begin
                            state_next = icdf_pkg::ST_DONE;
                        end else begin
                            state_next = icdf_pkg::ST_MUL;
                        end
                    end else if (at_last) begin
                        state_next = icdf_pkg::ST_DONE;
                    end
                end
            end
            icdf_pkg::ST_MUL:       state_next = icdf_pkg::ST_DIV_START;
            icdf_pkg::ST_DIV_START: state_next = icdf_pkg::ST_DIV_WAIT;
            icdf_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = icdf_pkg::ST_DONE;
                end
            end
            icdf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = icdf_pkg::ST_IDLE;
                end
            end
            default: state_next = icdf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= icdf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scan pointer and check pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
            issue_reg     <= '0;
        end else if (state_reg == icdf_pkg::ST_IDLE) begin
            chk_valid_reg <= 1'b0;
            issue_reg     <= '0;
        end else if (state_reg == icdf_pkg::ST_SCAN) begin
            chk_valid_reg <= 1'b1;
            issue_reg     <= issue_reg + 1'b1;
        end
    end

    // Scan and interpolation datapath.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            frac_reg <= in_frac;
        end
        if (state_reg == icdf_pkg::ST_SCAN) begin
            chk_idx_reg <= issue_reg;
            if (chk_valid_reg) begin
                prev_reg    <= rd_data_reg;
                res_seg_reg <= chk_idx_reg;
                if (hit && chk_idx_reg == '0) begin
                    res_energy_reg  <= rd_data_reg.energy;
                    res_outcome_reg <= icdf_pkg::OUT_FIRST;
                end else if (hit && flat) begin
                    res_energy_reg  <= rd_data_reg.energy;
                    res_outcome_reg <= icdf_pkg::OUT_FLAT;
                end else if (hit) begin
                    res_outcome_reg <= icdf_pkg::OUT_INTERP;
                end else begin
                    res_energy_reg  <= rd_data_reg.energy;
                    res_outcome_reg <= icdf_pkg::OUT_CLAMP;
                end
                // Segment deltas; only used when the hit interpolates.
                dr_reg   <= frac_reg - FW'(prev_reg.cdf);
                dc_reg   <= rd_data_reg.cdf - prev_reg.cdf;
                neg_reg  <= rd_data_reg.energy < prev_reg.energy;
                de_reg   <= (rd_data_reg.energy < prev_reg.energy)
                            ? prev_reg.energy - rd_data_reg.energy
                            : rd_data_reg.energy - prev_reg.energy;
                base_reg <= prev_reg.energy;
            end
        end
        if (state_reg == icdf_pkg::ST_MUL) begin
            prod_reg <= PW'(dr_reg) * PW'(de_reg);
        end
        if (state_reg == icdf_pkg::ST_DIV_WAIT && div_done) begin
            res_energy_reg <= neg_reg ? base_reg - div_q : base_reg + div_q;
        end
    end

    // Divider for the interpolation step.
    icdf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == icdf_pkg::ST_DIV_START),
        .dividend (prod_reg),
        .divisor  (dc_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output register; holds a result while the sink stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == icdf_pkg::ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == icdf_pkg::ST_DONE && out_free) begin
            m_energy_reg  <= res_energy_reg;
            m_seg_reg     <= res_seg_reg;
            m_outcome_reg <= res_outcome_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(icdf_pkg::M_TDATA_W - EW - IW)'(0), m_seg_reg, m_energy_reg};
    assign m_tuser  = m_outcome_reg;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == icdf_pkg::ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    // The scan never checks an entry beyond the last one in use.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == icdf_pkg::ST_SCAN && chk_valid_reg) |-> chk_idx_reg <= last_idx)
        else $error("scan ran past the last table entry in use");

    // A first-edge result always reports segment zero.
    a_first_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_outcome_reg == icdf_pkg::OUT_FIRST) |-> m_seg_reg == '0)
        else $error("first-edge result with nonzero segment");

    // A clamped result always reports the last entry in use.
    a_clamp_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_outcome_reg == icdf_pkg::OUT_CLAMP) |-> m_seg_reg == last_idx)
        else $error("clamped result does not report the last entry");

endmodule

>>> tb/sv/inverse_cdf_table_sampler_tb.sv
// Self-checking testbench for inverse_cdf_table_sampler: loads piecewise-linear CDF tables,
// draws samples from them and checks every result against a predictor of its own.
// Depends on icdf_pkg and the sampler RTL only.
import icdf_pkg::*;

// One expected or observed sample result.
typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [IDX_W-1:0]    segment;
    logic [1:0]          outcome;
} draw_t;

// Keeps a copy of the table and the length register, predicts each sample and
// checks the results in order.
class icdf_draw_checker;
    logic [ENERGY_W-1:0] edge_mev [TABLE_DEPTH];
    logic [CDF_W-1:0]    cdf_pt   [TABLE_DEPTH];
    logic [LEN_W-1:0]    length_reg;
    draw_t               expected_draws [$];
    int unsigned         errors;
    int unsigned         loads_seen;
    int unsigned         draws_seen;
    int unsigned         draws_checked;

    function new();
        length_reg    = 11'd1024;
        errors        = 0;
        loads_seen    = 0;
        draws_seen    = 0;
        draws_checked = 0;
    endfunction

    // The length register saturates into the range the table supports.
    function int unsigned entries_in_use();
        if (length_reg < 2) return 2;
        if (length_reg > TABLE_DEPTH) return TABLE_DEPTH;
        return length_reg;
    endfunction

    // First-hit scan, then the first edge, a clamp, a flat step or interpolation.
    function draw_t predict_draw(logic [FRAC_W-1:0] r);
        draw_t               d;
        int unsigned         n;
        int unsigned         k;
        logic [ENERGY_W-1:0] e1;
        logic [ENERGY_W-1:0] e2;
        logic [CDF_W-1:0]    c1;
        logic [CDF_W-1:0]    c2;
        logic [63:0]         span;
        logic [63:0]         step;
        logic [63:0]         q;
        n = entries_in_use();
        k = 0;
        while (k < n && cdf_pt[k] < {1'b0, r}) k++;
        if (k == 0) begin
            d.energy  = edge_mev[0];
            d.segment = '0;
            d.outcome = OUT_FIRST;
        end else if (k >= n) begin
            d.energy  = edge_mev[n-1];
            d.segment = IDX_W'(n - 1);
            d.outcome = OUT_CLAMP;
        end else begin
            e1 = edge_mev[k-1];
            e2 = edge_mev[k];
            c1 = cdf_pt[k-1];
            c2 = cdf_pt[k];
            d.segment = IDX_W'(k);
            if (c2 <= c1 || {1'b0, r} < c1) begin
                d.energy  = e2;
                d.outcome = OUT_FLAT;
            end else begin
                span = 64'(c2) - 64'(c1);
                step = 64'(r) - 64'(c1);
                // Truncating divide of the magnitude, applied from edge k-1 toward edge k.
                if (e2 >= e1) begin
                    q = step * (64'(e2) - 64'(e1)) / span;
                    d.energy = e1 + q[ENERGY_W-1:0];
                end else begin
                    q = step * (64'(e1) - 64'(e2)) / span;
                    d.energy = e1 - q[ENERGY_W-1:0];
                end
                d.outcome = OUT_INTERP;
            end
        end
        return d;
    endfunction

    // Called for every accepted request, in acceptance order.
    function void note_request(logic act, logic [IDX_W-1:0] at, logic [ENERGY_W-1:0] mev,
                               logic [CDF_W-1:0] cdf, logic [FRAC_W-1:0] frac);
        if (act == ACT_LOAD) begin
            edge_mev[at] = mev;
            cdf_pt[at]   = cdf;
            loads_seen++;
        end else begin
            expected_draws.push_back(predict_draw(frac));
            draws_seen++;
        end
    endfunction

    function void flag_field(string field, longint stamp, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0d ns: %s mismatch, expected %h, actual %h", stamp, field, want, got);
    endfunction

    // Called for every accepted result.
    function void check_result(logic [ENERGY_W-1:0] energy, logic [IDX_W-1:0] segment,
                               logic [1:0] outcome, longint stamp);
        draw_t want;
        if (expected_draws.size() == 0) begin
            errors++;
            $display("%0d ns: unexpected result, actual energy %h segment %h outcome %h",
                     stamp, energy, segment, outcome);
            return;
        end
        want = expected_draws.pop_front();
        draws_checked++;
        if (energy !== want.energy) flag_field("energy", stamp, want.energy, energy);
        if (segment !== want.segment) flag_field("segment", stamp, want.segment, segment);
        if (outcome !== want.outcome) flag_field("outcome", stamp, want.outcome, outcome);
    endfunction

    function void report_leftover();
        if (expected_draws.size() != 0) begin
            errors += expected_draws.size();
            $display("%0d results never arrived", expected_draws.size());
        end
    endfunction
endclass

module inverse_cdf_table_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [LEN_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    icdf_draw_checker board = new();

    // Stimulus side bookkeeping: which entries hold data, and their CDF values.
    bit                   loaded     [TABLE_DEPTH];
    logic [CDF_W-1:0]     shadow_cdf [TABLE_DEPTH];
    int                   src_idle_pct     = 8;
    int                   sink_idle_pct    = 47;
    int                   sink_hold_cycles = 0;

    inverse_cdf_table_sampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side ready: a long hold-off when asked, otherwise random stalls.
    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Check every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata[31:0], m_tdata[41:32], m_tuser, $time);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic act, input logic [IDX_W-1:0] at,
                                input logic [ENERGY_W-1:0] mev, input logic [CDF_W-1:0] cdf,
                                input logic [FRAC_W-1:0] frac);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, frac, cdf, mev, at};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(act, at, mev, cdf, frac);
        if (act == ACT_LOAD) begin
            loaded[at]     = 1'b1;
            shadow_cdf[at] = cdf;
        end
        @(negedge aclk);
    endtask

    // Unused fields carry random bits; the block must ignore them.
    task automatic load_entry(input logic [IDX_W-1:0] at, input logic [ENERGY_W-1:0] mev,
                              input logic [CDF_W-1:0] cdf);
        send_request(ACT_LOAD, at, mev, cdf, FRAC_W'($urandom));
    endtask

    task automatic draw_sample(input logic [FRAC_W-1:0] r);
        send_request(ACT_SAMPLE, IDX_W'($urandom), $urandom, CDF_W'($urandom), r);
    endtask

    // Stop offering requests and wait until every sample has returned its result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_draws.size() != 0) @(negedge aclk);
        // Loads are written when accepted, so none is pending; this wait is margin only.
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        board.length_reg = value;
    endtask

    // Load entries 0..n-1 with a nondecreasing CDF and rising, falling or random energies.
    task automatic build_curve(input int unsigned n);
        int unsigned         shape;
        int unsigned         i;
        longint unsigned     top;
        longint unsigned     c;
        logic [ENERGY_W-1:0] e;
        logic [CDF_W-1:0]    prev;
        shape = $urandom_range(3);
        // Some curves end below 1.0 so that high draws clamp.
        top = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF, 24'h400000) : 64'd16777216;
        e = (shape == 2) ? 32'hFFFF_FFFF - $urandom_range(32'h0010_0000)
                         : $urandom_range(32'h0010_0000);
        prev = '0;
        for (i = 0; i < n; i++) begin
            if (i == 0)
                c = ($urandom_range(3) == 0) ? 0 : $urandom_range(top / (2 * n));
            else if ($urandom_range(5) == 0)
                c = prev;
            else
                c = (longint'(i) * top) / (n - 1);
            if (i != 0) begin
                case (shape)
                    0: e = e + $urandom_range(32'h3FFF_FFFF / n);
                    1: e = e + $urandom_range(32'hFFEF_FFFF / n);
                    2: e = e - $urandom_range(32'hFFEF_FFFF / n);
                    default: e = $urandom;
                endcase
            end
            load_entry(IDX_W'(i), e, CDF_W'(c));
            prev = CDF_W'(c);
        end
    endtask

    // Draws aimed at stored CDF points, just past them, or anywhere.
    task automatic random_draw(input int unsigned n);
        int unsigned      k;
        logic [FRAC_W-1:0] r;
        k = $urandom_range(n - 1);
        case ($urandom_range(3))
            0: r = shadow_cdf[k][FRAC_W-1:0];
            1: r = shadow_cdf[k][FRAC_W-1:0] + 1'b1;
            default: r = FRAC_W'($urandom);
        endcase
        draw_sample(r);
    endtask

    // Run time limit.
    initial begin
        #10_000_000;
        $display("Timeout: the run did not finish in time");
        $display("end of test: mismatches");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [LEN_W-1:0] len_val;
        int unsigned      n;
        int unsigned      pick;
        int unsigned      j;
        int unsigned      phase_count;
        int unsigned      guard;
        bit               needs_fill;
        phase_count    = 0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // The length register comes out of reset at the full table.
        build_curve(TABLE_DEPTH);
        for (j = 0; j < 6; j++) random_draw(TABLE_DEPTH);

        // Directed: a four-entry curve with a falling segment, exact hits and clamps.
        set_length(11'd4);
        load_entry(10'd0, 32'h0000_0000, 25'h000_0100);
        load_entry(10'd1, 32'h0001_0000, 25'h080_0000);
        load_entry(10'd2, 32'hFFFF_FFFF, 25'h0C0_0000);
        load_entry(10'd3, 32'h8000_0000, 25'h100_0000);
        draw_sample(24'h00_0000);
        draw_sample(24'h00_0100);
        draw_sample(24'h00_0101);
        draw_sample(24'h40_0000);
        draw_sample(24'h80_0000);
        draw_sample(24'hA0_0000);
        draw_sample(24'hC0_0000);
        draw_sample(24'hFF_FFFF);
        // Every CDF value below the draw clamps to the last entry.
        load_entry(10'd3, 32'h1234_5678, 25'h0FF_FFFE);
        draw_sample(24'hFF_FFFF);
        // A CDF value above 1.0 is stored as given.
        load_entry(10'd3, 32'hFFFF_FFFF, 25'h1FF_FFFF);
        draw_sample(24'hFF_FFFF);
        // Lengths below two saturate to two.
        set_length(11'd0);
        draw_sample(24'hFF_FFFF);
        draw_sample(24'h00_0010);
        set_length(11'd1);
        draw_sample(24'h90_0000);

        // Random phases, each with its own length and mostly well-formed curves.
        while (phase_count < 8) begin
            pick = $urandom_range(9);
            if (pick == 0)
                len_val = 11'd2;
            else if (pick == 1)
                len_val = LEN_W'($urandom_range(1));
            else if (pick == 2)
                len_val = LEN_W'($urandom_range(200, 65));
            else
                len_val = LEN_W'($urandom_range(64, 3));
            n = (len_val < 2) ? 2 : len_val;

            if (phase_count < 3) begin
                src_idle_pct  = 8;
                sink_idle_pct = 47;
            end else if (phase_count < 6) begin
                src_idle_pct  = 47;
                sink_idle_pct = 8;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            set_length(len_val);
            // Back up the result side so the block stalls its input.
            if (phase_count == 0 || phase_count == 6) begin
                sink_hold_cycles = 2000;
            end

            needs_fill = 0;
            for (j = 0; j < n; j++) if (!loaded[j]) needs_fill = 1;
            if (needs_fill || $urandom_range(1) == 0) begin
                build_curve(n);
            end

            // Mostly draws, with some stray loads anywhere in the table.
            for (j = 0; j < 20; j++) begin
                if ($urandom_range(7) == 0)
                    load_entry(IDX_W'($urandom), $urandom, CDF_W'($urandom));
                else
                    random_draw(n);
            end
            phase_count++;
        end

        // Long scans: a saturated length and the full table length.
        set_length(11'd2047);
        for (j = 0; j < 6; j++) random_draw(TABLE_DEPTH);
        set_length(11'd1024);
        for (j = 0; j < 4; j++) random_draw(TABLE_DEPTH);

        // Wait for the last results, bounded.
        s_tvalid <= 1'b0;
        guard = 0;
        while (board.expected_draws.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (60) @(negedge aclk);
        board.report_leftover();

        $display("Run covered %0d table loads and %0d samples over %0d random phases.",
                 board.loads_seen, board.draws_seen, phase_count);
        $display("Results checked: %0d; lengths from saturated low to saturated high.",
                 board.draws_checked);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/icdf_pkg.sv
hdl/icdf_div.sv
hdl/inverse_cdf_table_sampler.sv
tb/sv/inverse_cdf_table_sampler_tb.sv
